@@ hw/rtl/gfau_pkg.sv @@
// ---------------------------------------------------------------------------
// GF(2^8) arithmetic unit package
// Shared widths, operation codes, sequencer states, the Euclid step state
// and the polynomial degree function.
// ---------------------------------------------------------------------------
`default_nettype none

package gfau_pkg;

    // Field geometry.
    localparam int FIELD_BITS = 8;
    localparam int ELEM_W     = FIELD_BITS;
    localparam int POLY_W     = FIELD_BITS + 1;
    localparam int DEG_W      = $clog2(POLY_W);
    localparam int CNT_W      = $clog2(FIELD_BITS);

    // Default reduction polynomial x^8+x^4+x^3+x+1.
    localparam logic [POLY_W-1:0] POLY_RESET = 9'h11B;

    // Operation codes.
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INV,
        ST_MUL,
        ST_DONE
    } gfau_state_t;

    // Working state of the binary extended Euclid inversion.
    // Only the low byte of the cofactors matters, as shifts move bits upward.
    typedef struct packed {
        logic [POLY_W-1:0] u;
        logic [POLY_W-1:0] v;
        logic [ELEM_W-1:0] g1;
        logic [ELEM_W-1:0] g2;
    } euclid_state_t;

    // Degree of a polynomial: index of its top set bit, zero for zero.
    function automatic logic [DEG_W-1:0] degree_of(input logic [POLY_W-1:0] x);
        logic [DEG_W-1:0] d;
        d = '0;
        for (int i = 1; i < POLY_W; i++) begin
            if (x[i])
            begin
                d = i[DEG_W-1:0];
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gf256_arithmetic_unit.sv @@
// ---------------------------------------------------------------------------
// GF(2^8) arithmetic unit
// Add, subtract, multiply and divide over GF(2^8) with a programmable
// reduction polynomial, using one shared shift-and-add multiplier and one
// Euclid step unit under a small sequencer.
// ---------------------------------------------------------------------------
// Sequence: add, subtract and divides by zero or of zero go straight to the
// finish state; a multiply runs 8 shift-and-add steps; other divides run one
// Euclid step per cycle to a remainder of one, then the 8 multiply steps.
// Throughput: one word at a time; a new word is taken once the sequencer is
// back in idle, while the previous result may still wait in the output register.
// Reset: sequencer idle, output empty, polynomial back to x^8+x^4+x^3+x+1.
`default_nettype none

module gf256_arithmetic_unit
    import gfau_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [POLY_W-1:0] cfg_data,
    // Input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        op,
    input  wire logic [ELEM_W-1:0] operand_a,
    input  wire logic [ELEM_W-1:0] operand_b,
    // Output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ELEM_W-1:0]      field_result,
    output logic                   div_by_zero
);

    gfau_state_t       state_reg,      state_next;
    logic [POLY_W-1:0] poly_reg;
    logic [ELEM_W-1:0] acc_reg,        acc_next;
    logic              flag_reg,       flag_next;
    logic [ELEM_W-1:0] mcand_reg,      mcand_next;
    logic [ELEM_W-1:0] mplier_reg,     mplier_next;
    logic [CNT_W-1:0]  cnt_reg,        cnt_next;
    euclid_state_t     euc_reg,        euc_next;
    euclid_state_t     euc_step;
    logic              out_valid_reg,  out_valid_next;
    logic [ELEM_W-1:0] out_result_reg;
    logic              out_flag_reg;
    logic              in_accept;
    logic              out_take;
    logic              out_load;
    logic [ELEM_W-1:0] poly_low;

    assign poly_low  = poly_reg[ELEM_W-1:0];
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Euclid step unit.
    gfau_euclid_step u_euclid_step (
        .cur (euc_reg),
        .nxt (euc_step)
    );

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        flag_next   = flag_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        euc_next    = euc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    acc_next    = '0;
                    flag_next   = 1'b0;
                    mcand_next  = operand_a;
                    mplier_next = operand_b;
                    cnt_next    = '0;
                    euc_next.u  = {1'b0, operand_b};
                    euc_next.v  = {1'b1, poly_low};
                    euc_next.g1 = ELEM_W'(1);
                    euc_next.g2 = '0;
                    unique case (op) inside
                        OP_ADD, OP_SUB:
                        begin
                            acc_next   = operand_a ^ operand_b;
                            state_next = ST_DONE;
                        end
                        OP_MUL:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_DIV:
                        begin
                            if (operand_b == '0)
                            begin
                                flag_next  = 1'b1;
                                state_next = ST_DONE;
                            end
                            else if (operand_a == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_INV;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            // One Euclid step a cycle until the remainder is one or zero.
            ST_INV:
            begin
                if (euc_reg.u == POLY_W'(1))
                begin
                    mplier_next = euc_reg.g1;
                    cnt_next    = '0;
                    state_next  = ST_MUL;
                end
                else if (euc_reg.u == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    euc_next = euc_step;
                end
            end

            // One shift-and-add step a cycle over the multiplier bits.
            ST_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg ^ mcand_reg;
                end
                if (mcand_reg[ELEM_W-1])
                begin
                    mcand_next = {mcand_reg[ELEM_W-2:0], 1'b0} ^ poly_low;
                end
                else
                begin
                    mcand_next = {mcand_reg[ELEM_W-2:0], 1'b0};
                end
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(FIELD_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            poly_reg      <= POLY_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                poly_reg <= cfg_data;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        flag_reg   <= flag_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
        euc_reg    <= euc_next;
        if (out_load)
        begin
            out_result_reg <= acc_reg;
            out_flag_reg   <= flag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign field_result = out_result_reg;
    assign div_by_zero  = out_flag_reg;

    // A divide-by-zero word always carries a zero element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flag_reg) |-> (out_result_reg == '0))
    else $error("divide-by-zero word with non-zero result");

    // The Euclid divisor never becomes zero during an inversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INV) |-> (euc_reg.v != '0))
    else $error("Euclid divisor reached zero");

    // A new output word only appears after the sequencer has finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
    else $error("output word loaded outside the finish state");

    // An accepted word always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
    else $error("accepted word did not start the sequencer");

endmodule

`default_nettype wire

@@ hw/rtl/gfau_euclid_step.sv @@
// ---------------------------------------------------------------------------
// GF(2^8) Euclid step
// One step of the binary extended Euclid inversion: align the lower-degree
// polynomial under the higher one and cancel its top term, updating the
// cofactors in the same way.
// ---------------------------------------------------------------------------
`default_nettype none

module gfau_euclid_step
    import gfau_pkg::*;
(
    input  euclid_state_t cur,
    output euclid_state_t nxt
);

    logic [DEG_W-1:0]  deg_u;
    logic [DEG_W-1:0]  deg_v;
    logic              swap;
    logic [DEG_W-1:0]  shift;
    logic [POLY_W-1:0] hi_poly;
    logic [POLY_W-1:0] lo_poly;
    logic [ELEM_W-1:0] hi_g;
    logic [ELEM_W-1:0] lo_g;

    // Degrees and the swap decision.
    assign deg_u = degree_of(cur.u);
    assign deg_v = degree_of(cur.v);
    assign swap  = (deg_u < deg_v);

    // Order the pair so that the higher-degree polynomial is reduced.
    always_comb
    begin
        if (swap)
        begin
            hi_poly = cur.v;
            lo_poly = cur.u;
            hi_g    = cur.g2;
            lo_g    = cur.g1;
            shift   = deg_v - deg_u;
        end
        else
        begin
            hi_poly = cur.u;
            lo_poly = cur.v;
            hi_g    = cur.g1;
            lo_g    = cur.g2;
            shift   = deg_u - deg_v;
        end
    end

    // Cancel the top term; the aligned divisor never exceeds the polynomial width.
    assign nxt.u  = hi_poly ^ (lo_poly << shift);
    assign nxt.v  = lo_poly;
    assign nxt.g1 = hi_g ^ (lo_g << shift);
    assign nxt.g2 = lo_g;

endmodule

`default_nettype wire
